// ===== hw/rtl/indexed_sequential_search_defines.svh =====
// ---------------------------------------------------------------------------
// Indexed sequential search: assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INDEXED_SEQUENTIAL_SEARCH_DEFINES_SVH
`define INDEXED_SEQUENTIAL_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define ISS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed_sequential_search: assertion failed");

// Next-cycle implication.
`define ISS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed_sequential_search: assertion failed");

`endif

// ===== hw/rtl/iss_pkg.sv =====
// ---------------------------------------------------------------------------
// Indexed sequential search package
// Table geometry, derived widths, command and status codes, probe struct.
// ---------------------------------------------------------------------------
`default_nettype none

package iss_pkg;

    localparam int PAGE_ITEMS = 64;
    localparam int MAX_PAGES  = 64;
    localparam int CAPACITY   = PAGE_ITEMS * MAX_PAGES;

    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 12;
    localparam int STAT_W = 2;

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int PG_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int PCNT_W = $clog2(MAX_PAGES + 1);
    localparam int OFF_W  = $clog2(PAGE_ITEMS + 1);

    typedef enum logic [0:0] {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_LOADED = 2'd0,
        ST_FULL   = 2'd1,
        ST_FOUND  = 2'd2,
        ST_MISS   = 2'd3
    } t_status;

    // One binary-search step over the window [lo, hi).
    typedef struct packed {
        logic             active;
        logic             hit;
        logic             go_low;
        logic [OFF_W-1:0] mid;
    } t_probe;

endpackage

`default_nettype wire

// ===== hw/rtl/iss_if.sv =====
// ---------------------------------------------------------------------------
// Indexed sequential search channels
// Command and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface iss_cmd_if;
    logic                             valid;
    logic                             ready;
    logic                             command;
    logic signed [iss_pkg::KEY_W-1:0] search_key;
    logic [iss_pkg::VAL_W-1:0]        record_value;

    modport source (output valid, command, search_key, record_value, input ready);
    modport sink   (input valid, command, search_key, record_value, output ready);
endinterface

interface iss_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [iss_pkg::STAT_W-1:0] status;
    logic [iss_pkg::VAL_W-1:0]  found_value;
    logic [iss_pkg::POS_W-1:0]  found_position;

    modport source (output valid, status, found_value, found_position, input ready);
    modport sink   (input valid, status, found_value, found_position, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/iss_probe.sv =====
// ---------------------------------------------------------------------------
// Indexed sequential search: binary-search probe
// Midpoint of the open window and the compare of the probed key.
// ---------------------------------------------------------------------------
`default_nettype none

module iss_probe (
    input  logic [iss_pkg::OFF_W-1:0]        i_lo,
    input  logic [iss_pkg::OFF_W-1:0]        i_hi,
    input  logic signed [iss_pkg::KEY_W-1:0] i_rec_key,
    input  logic signed [iss_pkg::KEY_W-1:0] i_key,
    output iss_pkg::t_probe                  o_probe
);

    logic [iss_pkg::OFF_W-1:0] w_span;

    // Span is hi - 1 - lo; only meaningful while the window is open.
    assign w_span = i_hi - i_lo - iss_pkg::OFF_W'(1);

    always_comb begin
        o_probe.active = (i_lo < i_hi);
        o_probe.mid    = i_lo + (w_span >> 1);
        o_probe.hit    = (i_rec_key == i_key);
        o_probe.go_low = (i_rec_key > i_key);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/indexed_sequential_search.sv =====
// ---------------------------------------------------------------------------
// Indexed sequential search
// Paged record table with a page index, loaded in key order and searched.
// ---------------------------------------------------------------------------
// Usage:
//   i_cmd carries one word per command: command (load or search), search_key
//   and record_value. o_rsp returns exactly one word per command: status,
//   found_value and found_position.
//   A load appends one record in S_LOAD and passes its result on through
//   S_DONE to the response register.
//   A load into a full table stores nothing and answers with the full status.
//   A search walks the page index, one entry per cycle from the page index
//   memory, then binary-searches the chosen page with probes on the record
//   memory, each a read (S_BS_RD) and then a compare (S_BS_CMP); a window
//   that runs empty closes the search with a miss.
//   Every command closes in S_DONE, from which its result goes into the
//   response register.
//   One command is worked on at a time; i_cmd.ready is high while idle.
//   The response register parts the two sides: a new command is accepted
//   while a finished response still waits for o_rsp.ready. If the receiver
//   stalls longer, the next result waits in the engine and no further command
//   is taken.
//   Reset clears the record count and the page count; the memories keep
//   their contents, which are only read below the count. No clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

`include "indexed_sequential_search_defines.svh"

module indexed_sequential_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iss_cmd_if.sink     i_cmd,
    iss_rsp_if.source   o_rsp
);

    localparam int KEY_W  = iss_pkg::KEY_W;
    localparam int VAL_W  = iss_pkg::VAL_W;
    localparam int POS_W  = iss_pkg::POS_W;
    localparam int STAT_W = iss_pkg::STAT_W;
    localparam int ADDR_W = iss_pkg::ADDR_W;
    localparam int CNT_W  = iss_pkg::CNT_W;
    localparam int PG_W   = iss_pkg::PG_W;
    localparam int PCNT_W = iss_pkg::PCNT_W;
    localparam int OFF_W  = iss_pkg::OFF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_BS_RD,
        S_BS_CMP,
        S_DONE
    } t_state;

    // Control and work registers
    t_state                   r_state;
    logic signed [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]         r_val;
    logic [CNT_W-1:0]         r_count;   // records stored
    logic [PCNT_W-1:0]        r_pages;   // pages started
    logic [OFF_W-1:0]         r_fill;    // records in the last page
    logic [PCNT_W-1:0]        r_issue;   // next page index entry to read
    logic                     r_pend;    // page read data valid this cycle
    logic [PCNT_W-1:0]        r_p;       // page entries passed so far
    logic [OFF_W-1:0]         r_lo;
    logic [OFF_W-1:0]         r_hi;      // exclusive upper bound
    logic [ADDR_W-1:0]        r_base;

    // Pending result and response register
    iss_pkg::t_status         r_res_status;
    logic [VAL_W-1:0]         r_res_val;
    logic [POS_W-1:0]         r_res_pos;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [STAT_W-1:0]        r_out_status;
    logic [VAL_W-1:0]         r_out_val;
    logic [POS_W-1:0]         r_out_pos;

    // Memories: records as {key, value}, page index as first keys
    logic [KEY_W+VAL_W-1:0]   r_rec_mem [iss_pkg::CAPACITY];
    logic [KEY_W+VAL_W-1:0]   r_rec_rdata;
    logic [KEY_W-1:0]         r_page_mem [iss_pkg::MAX_PAGES];
    logic [KEY_W-1:0]         r_page_rdata;

    logic                     w_acc;
    logic                     w_full;
    logic                     w_new_page;
    logic                     w_load_we;
    logic                     w_page_we;
    logic [ADDR_W-1:0]        w_rec_waddr;
    logic [ADDR_W-1:0]        w_rec_raddr;
    logic [PG_W-1:0]          w_page_waddr;
    logic [PG_W-1:0]          w_page_raddr;
    logic                     w_pass;
    logic                     w_scan_end;
    logic [PCNT_W-1:0]        n_p;
    logic [OFF_W-1:0]         n_len;
    logic [ADDR_W-1:0]        n_base;
    logic                     w_out_free;
    iss_pkg::t_probe          w_probe;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_acc       = i_cmd.valid && i_cmd.ready;

    assign w_full       = (r_count >= CNT_W'(iss_pkg::CAPACITY));
    assign w_new_page   = (r_pages == '0) || (r_fill == OFF_W'(iss_pkg::PAGE_ITEMS));
    assign w_load_we    = (r_state == S_LOAD) && !w_full;
    assign w_page_we    = w_load_we && w_new_page;
    assign w_rec_waddr  = r_count[ADDR_W-1:0];
    assign w_page_waddr = r_pages[PG_W-1:0];
    assign w_page_raddr = r_issue[PG_W-1:0];
    assign w_rec_raddr  = r_base + ADDR_W'(w_probe.mid);

    // Page scan: stop at the first index entry above the key.
    assign w_pass     = ($signed(r_page_rdata) <= r_key);
    assign n_p        = r_p + PCNT_W'(r_pend && w_pass);
    assign w_scan_end = (r_pend && !w_pass) || (r_issue == r_pages);

    // Window of the chosen page; the last page uses its fill.
    assign n_len  = (n_p == r_pages) ? r_fill : OFF_W'(iss_pkg::PAGE_ITEMS);
    assign n_base = ADDR_W'(int'(n_p - PCNT_W'(1)) * iss_pkg::PAGE_ITEMS);

    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Fill the response register from S_DONE, drop it once taken.
    assign n_out_valid = ((r_state == S_DONE) && w_out_free) || (r_out_valid && !o_rsp.ready);

    iss_probe u_probe (
        .i_lo      (r_lo),
        .i_hi      (r_hi),
        .i_rec_key ($signed(r_rec_rdata[KEY_W+VAL_W-1:VAL_W])),
        .i_key     (r_key),
        .o_probe   (w_probe)
    );

    // Record memory: one write port (load), one registered read port (probe).
    always_ff @(posedge i_clk) begin
        if (w_load_we) begin
            r_rec_mem[w_rec_waddr] <= {r_key, r_val};
        end
        r_rec_rdata <= r_rec_mem[w_rec_raddr];
    end

    // Page index memory: written when a load starts a page, read by the scan.
    always_ff @(posedge i_clk) begin
        if (w_page_we) begin
            r_page_mem[w_page_waddr] <= r_key;
        end
        r_page_rdata <= r_page_mem[w_page_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pages     <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_key   <= i_cmd.search_key;
                        r_val   <= i_cmd.record_value;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_p     <= '0;
                        if (iss_pkg::t_cmd'(i_cmd.command) == iss_pkg::CMD_SEARCH) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end

                S_LOAD: begin
                    r_res_val <= '0;
                    r_res_pos <= '0;
                    if (w_full) begin
                        r_res_status <= iss_pkg::ST_FULL;
                    end else begin
                        r_res_status <= iss_pkg::ST_LOADED;
                        r_count      <= r_count + CNT_W'(1);
                        if (w_new_page) begin
                            r_pages <= r_pages + PCNT_W'(1);
                            r_fill  <= OFF_W'(1);
                        end else begin
                            r_fill  <= r_fill + OFF_W'(1);
                        end
                    end
                    r_state <= S_DONE;
                end

                S_SCAN: begin
                    r_p <= n_p;
                    if (w_scan_end) begin
                        r_pend <= 1'b0;
                        if (n_p == '0) begin
                            r_res_status <= iss_pkg::ST_MISS;
                            r_res_val    <= '0;
                            r_res_pos    <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_lo    <= '0;
                            r_hi    <= n_len;
                            r_base  <= n_base;
                            r_state <= S_BS_RD;
                        end
                    end else begin
                        // Read-ahead: the next entry is read while this one is checked.
                        r_issue <= r_issue + PCNT_W'(1);
                        r_pend  <= 1'b1;
                    end
                end

                S_BS_RD: begin
                    if (w_probe.active) begin
                        r_state <= S_BS_CMP;
                    end else begin
                        r_res_status <= iss_pkg::ST_MISS;
                        r_res_val    <= '0;
                        r_res_pos    <= '0;
                        r_state      <= S_DONE;
                    end
                end

                S_BS_CMP: begin
                    if (w_probe.hit) begin
                        r_res_status <= iss_pkg::ST_FOUND;
                        r_res_val    <= r_rec_rdata[VAL_W-1:0];
                        r_res_pos    <= POS_W'(w_rec_raddr);
                        r_state      <= S_DONE;
                    end else begin
                        if (w_probe.go_low) begin
                            r_hi <= w_probe.mid;
                        end else begin
                            r_lo <= w_probe.mid + OFF_W'(1);
                        end
                        r_state <= S_BS_RD;
                    end
                end

                S_DONE: begin
                    // Hold the result until the response register is free.
                    if (w_out_free) begin
                        r_out_status <= r_res_status;
                        r_out_val    <= r_res_val;
                        r_out_pos    <= r_res_pos;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_value    = r_out_val;
    assign o_rsp.found_position = r_out_pos;

    `ISS_ASSERT_IMPL(a_count_cap, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(iss_pkg::CAPACITY))
    `ISS_ASSERT_IMPL(a_empty_fill, i_clk, i_rst_n, r_pages == '0, r_fill == '0)
    `ISS_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, r_state == S_LOAD && !w_full, r_count == $past(r_count) + 1'b1)
    `ISS_ASSERT_IMPL(a_window, i_clk, i_rst_n, r_state == S_BS_RD || r_state == S_BS_CMP, r_lo <= r_hi && r_hi <= OFF_W'(iss_pkg::PAGE_ITEMS))
    `ISS_ASSERT_IMPL(a_scan_bound, i_clk, i_rst_n, r_state == S_SCAN, r_issue <= r_pages && r_p <= r_issue)

endmodule

`default_nettype wire

// ===== bench/tb_indexed_sequential_search.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Indexed sequential search testbench
// Loads a paged key table through the command channel and searches it. A
// shadow copy of the table in the bench works out the status, data word and
// position of each response word without a known answer. The run starts with a short stimulus
// table, then mixed loads and searches on a growing table, and ends with
// searches at the key extremes and on keys of the table. Both channels idle
// and stall at random.
// ---------------------------------------------------------------------------

module tb_indexed_sequential_search;

    localparam int KEY_W      = iss_pkg::KEY_W;
    localparam int VAL_W      = iss_pkg::VAL_W;
    localparam int POS_W      = iss_pkg::POS_W;
    localparam int CAPACITY   = iss_pkg::CAPACITY;
    localparam int PAGE_ITEMS = iss_pkg::PAGE_ITEMS;
    localparam int MAX_PAGES  = iss_pkg::MAX_PAGES;

    // Response word as the bench predicts it.
    typedef struct packed {
        iss_pkg::t_status status;
        logic [VAL_W-1:0] value;
        logic [POS_W-1:0] pos;
    } t_answer;

    // One row of the stimulus table; known rows carry their own answer.
    typedef struct packed {
        iss_pkg::t_cmd    cmd;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        logic             known;
        t_answer          want;
    } t_step_row;

    localparam int     DIRECTED_ROWS  = 16;
    localparam int     RANDOM_WORDS   = 680;
    localparam int     FINAL_SEARCHES = 50;
    localparam int     SETTLE_CYCLES  = 120;
    localparam int     MAX_GAP        = 17;

    // Table starts empty. Rows without a known answer go to the predictor.
    localparam t_step_row DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // empty table: any search misses
        '{iss_pkg::CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b1,
          '{iss_pkg::ST_MISS, 32'h0, 12'h0}},
        '{iss_pkg::CMD_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1,
          '{iss_pkg::ST_MISS, 32'h0, 12'h0}},
        // first record one above the most negative key
        '{iss_pkg::CMD_LOAD,   32'h8000_0001, 32'h0000_0000, 1'b1,
          '{iss_pkg::ST_LOADED, 32'h0, 12'h0}},
        // key below the first page's first key
        '{iss_pkg::CMD_SEARCH, 32'h8000_0000, 32'h0000_0000, 1'b1,
          '{iss_pkg::ST_MISS, 32'h0, 12'h0}},
        '{iss_pkg::CMD_SEARCH, 32'h8000_0001, 32'h0000_0000, 1'b1,
          '{iss_pkg::ST_FOUND, 32'h0, 12'h0}},
        '{iss_pkg::CMD_LOAD,   32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
          '{iss_pkg::ST_LOADED, 32'h0, 12'h0}},
        '{iss_pkg::CMD_LOAD,   32'h0000_0005, 32'h5A5A_A5A5, 1'b1,
          '{iss_pkg::ST_LOADED, 32'h0, 12'h0}},
        '{iss_pkg::CMD_SEARCH, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
        '{iss_pkg::CMD_SEARCH, 32'h0000_0005, 32'h0000_0000, 1'b0, '0},
        // above every key, and a gap between keys
        '{iss_pkg::CMD_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
        '{iss_pkg::CMD_SEARCH, 32'h0000_0003, 32'h0000_0000, 1'b0, '0},
        // duplicate key: the first probe that hits wins
        '{iss_pkg::CMD_LOAD,   32'h0000_0005, 32'h1234_5678, 1'b1,
          '{iss_pkg::ST_LOADED, 32'h0, 12'h0}},
        '{iss_pkg::CMD_SEARCH, 32'h0000_0005, 32'h0000_0000, 1'b0, '0},
        // out-of-order load: the fixed search may miss it
        '{iss_pkg::CMD_LOAD,   32'hFFFF_FFF6, 32'hDEAD_BEEF, 1'b1,
          '{iss_pkg::ST_LOADED, 32'h0, 12'h0}},
        '{iss_pkg::CMD_SEARCH, 32'hFFFF_FFF6, 32'h0000_0000, 1'b0, '0},
        // record_value must be ignored on a search
        '{iss_pkg::CMD_SEARCH, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    iss_cmd_if cmd_if ();
    iss_rsp_if rsp_if ();

    indexed_sequential_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if)
    );

    // Shadow table: only entries below shadow_count are ever read.
    logic signed [KEY_W-1:0] shadow_keys   [CAPACITY];
    logic        [VAL_W-1:0] shadow_vals   [CAPACITY];
    logic signed [KEY_W-1:0] shadow_firsts [MAX_PAGES];
    int unsigned             shadow_count;

    t_answer pending_answers [$];
    int      mismatch_count;
    int      send_quiet;
    int      recv_quiet;
    longint  top_key;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // Apply one command to the shadow table and return its response word.
    function automatic t_answer table_answer(input iss_pkg::t_cmd cmd,
                                             input logic signed [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] val);
        t_answer                 ans;
        int unsigned             pages;
        int unsigned             pg;
        int unsigned             len;
        int unsigned             base;
        int unsigned             idx;
        int                      lo;
        int                      hi;
        int                      mid;
        logic signed [KEY_W-1:0] probe;
        ans = '{iss_pkg::ST_MISS, '0, '0};
        if (cmd == iss_pkg::CMD_LOAD) begin
            if (shadow_count >= CAPACITY) begin
                ans.status = iss_pkg::ST_FULL;
                return ans;
            end
            shadow_keys[shadow_count] = key;
            shadow_vals[shadow_count] = val;
            if (shadow_count % PAGE_ITEMS == 0)
                shadow_firsts[shadow_count / PAGE_ITEMS] = key;
            shadow_count++;
            ans.status = iss_pkg::ST_LOADED;
            return ans;
        end
        // Scan the page index for the last page starting at or below key.
        pages = (shadow_count + PAGE_ITEMS - 1) / PAGE_ITEMS;
        if (pages > MAX_PAGES)
            pages = MAX_PAGES;
        pg = 0;
        while (pg < pages && shadow_firsts[pg] <= key)
            pg++;
        if (pg == 0)
            return ans;
        // The last page only holds the records loaded so far.
        len = (pg < pages) ? PAGE_ITEMS : shadow_count % PAGE_ITEMS;
        if (len == 0)
            len = PAGE_ITEMS;
        base = (pg - 1) * PAGE_ITEMS;
        lo = 0;
        hi = int'(len) - 1;
        while (hi >= lo) begin
            mid = lo + (hi - lo) / 2;
            idx = base + mid;
            if (idx >= CAPACITY)
                break;
            probe = shadow_keys[idx];
            if (probe == key) begin
                ans.status = iss_pkg::ST_FOUND;
                ans.value  = shadow_vals[idx];
                ans.pos    = idx[POS_W-1:0];
                return ans;
            end
            if (probe > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return ans;
    endfunction

    // Random idle wait before each word, at most MAX_GAP, with runs of back-to-back words.
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
            quiet = $urandom_range(5, 30);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Mostly keys that are in the table, then neighbors, misses and noise.
    function automatic logic [KEY_W-1:0] search_pick();
        int unsigned      r;
        logic [KEY_W-1:0] k;
        r = $urandom_range(0, 99);
        if (shadow_count == 0 || r >= 90)
            return $urandom;
        k = shadow_keys[$urandom_range(0, shadow_count - 1)];
        if (r < 60)
            return k;
        if (r < 75)
            return k + 1;
        if (r < 85)
            return k - 1;
        return shadow_firsts[0] - 1;
    endfunction

    // Drive one command word; hold valid until it is taken, then log the answer.
    task automatic send_word(input iss_pkg::t_cmd cmd, input logic [KEY_W-1:0] key,
                             input logic [VAL_W-1:0] val,
                             input logic known = 1'b0, input t_answer want = '0);
        int      gap;
        t_answer predicted;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= cmd;
        cmd_if.search_key   <= key;
        cmd_if.record_value <= val;
        do @(posedge i_clk); while (!cmd_if.ready);
        predicted = table_answer(cmd, key, val);
        pending_answers.push_back(known ? want : predicted);
    endtask

    // Drop valid and hold off until every response word is back.
    task automatic drain_answers();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_answers.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus.
    initial begin
        int unsigned      lsel;
        logic [KEY_W-1:0] key;

        i_rst_n             = 1'b0;
        cmd_if.valid        = 1'b0;
        cmd_if.command      = iss_pkg::CMD_LOAD;
        cmd_if.search_key   = '0;
        cmd_if.record_value = '0;
        shadow_count        = 0;
        mismatch_count      = 0;
        send_quiet          = 0;
        top_key             = 5;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_word(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].key, DIRECTED_STEPS[i].val,
                      DIRECTED_STEPS[i].known, DIRECTED_STEPS[i].want);
        end

        // Growing table: ascending loads with a few duplicates and strays,
        // searches mostly on keys that are present.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if ($urandom_range(0, 99) < 40) begin
                lsel = $urandom_range(0, 19);
                if (lsel == 0) begin
                    key = $urandom;
                end else if (lsel == 1) begin
                    key = top_key[KEY_W-1:0];
                end else begin
                    top_key += $urandom_range(1, 1 << 19);
                    key = top_key[KEY_W-1:0];
                end
                send_word(iss_pkg::CMD_LOAD, key, $urandom);
            end else begin
                send_word(iss_pkg::CMD_SEARCH, search_pick(), $urandom);
            end
        end

        drain_answers();

        // Key extremes, then searches drawn mostly from keys loaded so far.
        send_word(iss_pkg::CMD_SEARCH, 32'h7FFF_FFFF, $urandom);
        send_word(iss_pkg::CMD_SEARCH, 32'h8000_0000, $urandom);
        for (int n = 0; n < FINAL_SEARCHES; n++)
            send_word(iss_pkg::CMD_SEARCH, search_pick(), $urandom);

        drain_answers();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Response side: stall a random number of cycles before each word.
    initial begin
        int gap;
        rsp_if.ready = 1'b0;
        recv_quiet   = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = draw_gap(recv_quiet);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    // Compare each taken response word with the oldest expected answer.
    always @(posedge i_clk) begin : check_rsp
        t_answer got;
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            got = '{iss_pkg::t_status'(rsp_if.status), rsp_if.found_value,
                    rsp_if.found_position};
            if (pending_answers.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: response word with nothing pending: status %0d value %h pos %0d",
                             $realtime, got.status, got.value, got.pos);
                mismatch_count++;
            end else begin
                want = pending_answers.pop_front();
                if (got.status != want.status || got.value != want.value
                        || got.pos != want.pos) begin
                    if (mismatch_count < 10)
                        $display("%0t: expected status %0d value %h pos %0d, got status %0d value %h pos %0d",
                                 $realtime, want.status, want.value, want.pos,
                                 got.status, got.value, got.pos);
                    mismatch_count++;
                end
            end
        end
    end

endmodule
